// ===== sv/usb_endpoint_context_builder_core_macros.svh =====
// Assertion macros shared by the endpoint context builder checkers.
// No dependencies; include by bare file name.
`ifndef USB_ENDPOINT_CONTEXT_BUILDER_CORE_MACROS_SVH
`define USB_ENDPOINT_CONTEXT_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USBEPC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("usbepc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define USBEPC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("usbepc check failed");

`endif

// ===== sv/usbepc_pkg.sv =====
// Types and constants for the USB endpoint context builder.
// No dependencies; used by the core and its checker.
package usbepc_pkg;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 112;

  // Descriptor transfer type, attributes bits 1:0
  typedef enum logic [1:0] {
    XFER_CONTROL = 2'd0,
    XFER_ISOCH   = 2'd1,
    XFER_BULK    = 2'd2,
    XFER_INTR    = 2'd3
  } xfer_type_e;

  // xHCI endpoint type codes
  localparam logic [2:0] KIND_ISO_OUT  = 3'd1;
  localparam logic [2:0] KIND_BULK_OUT = 3'd2;
  localparam logic [2:0] KIND_INT_OUT  = 3'd3;
  localparam logic [2:0] KIND_CONTROL  = 3'd4;
  localparam logic [2:0] KIND_ISO_IN   = 3'd5;
  localparam logic [2:0] KIND_BULK_IN  = 3'd6;
  localparam logic [2:0] KIND_INT_IN   = 3'd7;

  // Port speed codes
  localparam logic [3:0] SPEED_FULL  = 4'd1;
  localparam logic [3:0] SPEED_LOW   = 4'd2;
  localparam logic [3:0] SPEED_HIGH  = 4'd3;
  localparam logic [3:0] SPEED_SUPER = 4'd4;

  localparam logic [1:0]  ERR_LIMIT_MAX = 2'd3;
  localparam logic [19:0] CTRL_AVG_TRB  = 20'd8;

  typedef struct packed {
    logic [7:0]  ep_addr;
    logic [7:0]  attr;
    logic [15:0] mps_raw;
    logic [7:0]  ival;
    logic        comp;
    logic [3:0]  comp_burst;
    logic [15:0] comp_bpi;
  } desc_t;

  typedef struct packed {
    logic [4:0]  ctx_index;
    logic [31:0] add_mask;
    logic [4:0]  ctx_entries;
    logic [2:0]  kind;
    logic [4:0]  ival_code;
    logic [1:0]  err_limit;
    logic [15:0] mps;
    logic [3:0]  burst;
    logic [15:0] esit;
    logic [19:0] avg_trb;
  } ctx_t;

endpackage

// ===== sv/usb_endpoint_context_builder_core.sv =====
// Endpoint context builder: USB endpoint descriptor in, xHCI endpoint context
// fields out. An input register feeds a result register; one transfer
// per cycle sustained, stalls only when the output side holds off.
// Decode is plain combinational logic between the two registers; the running
// highest context index updates as each result is loaded. Types from usbepc_pkg.
// Reset (rst_ni low, async) empties both stages, clears highest index and
// port speed to 0.
module usb_endpoint_context_builder_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Config: port speed register
  input  logic                            cfg_we_i,
  input  logic [3:0]                      cfg_wdata_i,
  // Descriptor stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] endpoint_address, [15:8] attributes, [31:16] max_packet_field,
  // [39:32] interval_field, [43:40] companion_burst,
  // [59:44] companion_bytes_per_interval, [63:60] zero
  input  logic [usbepc_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] companion_present
  input  logic                            s_axis_tuser,
  // Context stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [4:0] context_index, [36:5] slot add mask, [41:37] context count,
  // [46:42] interval_code, [48:47] error_limit, [64:49] packet_size,
  // [68:65] burst, [84:69] esit_payload, [104:85] avg TRB length,
  // [111:105] zero
  output logic [usbepc_pkg::OutDataW-1:0] m_axis_tdata,
  // [2:0] endpoint_kind
  output logic [2:0]                      m_axis_tuser
);

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  logic [3:0]        speed_q;
  logic              in_valid_q;
  usbepc_pkg::desc_t in_q;
  logic              out_valid_q;
  usbepc_pkg::ctx_t  res_q;
  logic [4:0]        highest_q;

  usbepc_pkg::desc_t in_d;
  usbepc_pkg::ctx_t  res_d;
  logic [4:0]        highest_d;

  // Stage handshakes: each stage takes a new item when empty or draining.
  logic out_ready;
  logic in_load;
  logic res_load;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign in_load       = s_axis_tvalid && s_axis_tready;
  assign res_load      = in_valid_q && out_ready;

  // Unpack the input transfer
  always_comb begin
    in_d.ep_addr    = s_axis_tdata[7:0];
    in_d.attr       = s_axis_tdata[15:8];
    in_d.mps_raw    = s_axis_tdata[31:16];
    in_d.ival       = s_axis_tdata[39:32];
    in_d.comp_burst = s_axis_tdata[43:40];
    in_d.comp_bpi   = s_axis_tdata[59:44];
    in_d.comp       = s_axis_tuser;
  end

  // ---------------------------------------------------------------------
  // Interval exponent helpers
  // ---------------------------------------------------------------------
  // clamp(ival, 1, 16)
  function automatic logic [4:0] clamp16(input logic [7:0] v);
    logic [4:0] r;
    if (v == 8'd0) begin
      r = 5'd1;
    end else if (v > 8'd16) begin
      r = 5'd16;
    end else begin
      r = v[4:0];
    end
    return r;
  endfunction

  // Low-speed rule: floor(log2(clamp(ival*8, 1, 255))) clamped to 3..10.
  // ival*8 saturates at 255 once ival >= 32, so the result tops out at 7;
  // below that it is floor(log2(ival)) + 3, and ival of zero gives 3.
  function automatic logic [4:0] low_exp(input logic [7:0] v);
    logic [4:0] r;
    if (v[7:5] != 3'd0) begin
      r = 5'd7;
    end else if (v[4]) begin
      r = 5'd7;
    end else if (v[3]) begin
      r = 5'd6;
    end else if (v[2]) begin
      r = 5'd5;
    end else if (v[1]) begin
      r = 5'd4;
    end else begin
      r = 5'd3;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------
  usbepc_pkg::xfer_type_e ep_type;
  logic                   dir_in;
  logic                   periodic;
  logic [4:0]             idx;
  logic [15:0]            mps;
  logic [3:0]             burst;
  logic [4:0]             burst_p1;
  logic [19:0]            burst_payload;
  logic [4:0]             ival_clamped;

  always_comb begin
    ep_type  = usbepc_pkg::xfer_type_e'(in_q.attr[1:0]);
    dir_in   = in_q.ep_addr[7];
    idx      = {in_q.ep_addr[3:0], dir_in};
    periodic = (ep_type == usbepc_pkg::XFER_ISOCH) || (ep_type == usbepc_pkg::XFER_INTR);

    // Periodic endpoints keep only bits 10:0 as the packet size
    mps = periodic ? {5'd0, in_q.mps_raw[10:0]} : in_q.mps_raw;

    // Burst from the companion if present, else raw bits 12:11 if periodic, else zero
    if (in_q.comp) begin
      burst = in_q.comp_burst;
    end else if (periodic) begin
      burst = {2'd0, in_q.mps_raw[12:11]};
    end else begin
      burst = 4'd0;
    end

    // 65535 * 16 still fits in 20 bits
    burst_p1      = {1'b0, burst} + 5'd1;
    burst_payload = 20'(mps) * 20'(burst_p1);
    ival_clamped  = clamp16(in_q.ival);

    highest_d = (idx > highest_q) ? idx : highest_q;

    res_d.ctx_index   = idx;
    res_d.add_mask    = (32'd1 << idx) | 32'd1;
    res_d.ctx_entries = highest_d;
    res_d.mps         = mps;
    res_d.burst       = burst;
    res_d.err_limit   = (ep_type == usbepc_pkg::XFER_ISOCH) ? 2'd0
                                                            : usbepc_pkg::ERR_LIMIT_MAX;
    res_d.esit        = !periodic ? 16'd0 :
                        in_q.comp ? in_q.comp_bpi : burst_payload[15:0];

    case (ep_type)
      usbepc_pkg::XFER_CONTROL: begin
        res_d.kind      = usbepc_pkg::KIND_CONTROL;
        res_d.avg_trb   = usbepc_pkg::CTRL_AVG_TRB;
        res_d.ival_code = 5'd0;
      end
      usbepc_pkg::XFER_ISOCH: begin
        res_d.kind    = dir_in ? usbepc_pkg::KIND_ISO_IN : usbepc_pkg::KIND_ISO_OUT;
        res_d.avg_trb = {4'd0, mps};
        if (speed_q == usbepc_pkg::SPEED_FULL) begin
          res_d.ival_code = ival_clamped + 5'd2;
        end else if (speed_q == usbepc_pkg::SPEED_LOW) begin
          res_d.ival_code = low_exp(in_q.ival);
        end else begin
          res_d.ival_code = ival_clamped - 5'd1;
        end
      end
      usbepc_pkg::XFER_BULK: begin
        res_d.kind      = dir_in ? usbepc_pkg::KIND_BULK_IN : usbepc_pkg::KIND_BULK_OUT;
        res_d.avg_trb   = burst_payload;
        res_d.ival_code = 5'd0;
      end
      default: begin
        // Interrupt: full speed shares the low-speed rule
        res_d.kind    = dir_in ? usbepc_pkg::KIND_INT_IN : usbepc_pkg::KIND_INT_OUT;
        res_d.avg_trb = burst_payload;
        if ((speed_q == usbepc_pkg::SPEED_FULL) || (speed_q == usbepc_pkg::SPEED_LOW)) begin
          res_d.ival_code = low_exp(in_q.ival);
        end else begin
          res_d.ival_code = ival_clamped - 5'd1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= 4'd0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      highest_q   <= 5'd0;
    end else begin
      if (cfg_we_i) begin
        speed_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
      if (res_load) begin
        highest_q <= highest_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= in_d;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // ---------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tdata  = {7'd0, res_q.avg_trb, res_q.esit, res_q.burst, res_q.mps,
                          res_q.err_limit, res_q.ival_code, res_q.ctx_entries,
                          res_q.add_mask, res_q.ctx_index};

endmodule

// ===== sv/usbepc_checker.sv =====
// Port-level checks for usb_endpoint_context_builder_core, bound to it below.
// Depends on usbepc_pkg and the core's macro header.
`include "usb_endpoint_context_builder_core_macros.svh"

module usbepc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [usbepc_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [2:0]                      m_axis_tuser
);

  logic                            out_xfer;
  logic                            out_stall;
  logic                            is_iso;
  logic                            is_ctrl;
  logic [usbepc_pkg::OutDataW+3:0] out_word;
  logic                            entries_ok;
  logic                            ctrl_ok;
  logic                            err_ok;

  assign out_xfer  = m_axis_tvalid && m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};
  assign is_iso    = (m_axis_tuser == usbepc_pkg::KIND_ISO_IN) ||
                     (m_axis_tuser == usbepc_pkg::KIND_ISO_OUT);
  assign is_ctrl   = (m_axis_tuser == usbepc_pkg::KIND_CONTROL);

  assign entries_ok = m_axis_tdata[5] && (m_axis_tdata[41:37] >= m_axis_tdata[4:0]);
  assign ctrl_ok    = (m_axis_tdata[46:42] == 5'd0) && (m_axis_tdata[84:69] == 16'd0) &&
                      (m_axis_tdata[104:85] == usbepc_pkg::CTRL_AVG_TRB);
  assign err_ok     = (m_axis_tdata[48:47] == 2'd0) == is_iso;

  // A stalled result holds, valid included
  `USBEPC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, $stable(out_word))

  // Slot bit always set, entries count covers this endpoint
  `USBEPC_ASSERT_IMP(a_entries, clk_i, rst_ni, out_xfer, entries_ok)

  // Control endpoints: no interval, no ESIT payload, fixed average TRB length
  `USBEPC_ASSERT_IMP(a_control, clk_i, rst_ni, out_xfer && is_ctrl, ctrl_ok)

  // Error limit is zero exactly for isochronous endpoints
  `USBEPC_ASSERT_IMP(a_err_limit, clk_i, rst_ni, out_xfer, err_ok)

endmodule

bind usb_endpoint_context_builder_core usbepc_checker u_usbepc_checker (.*);

// ===== sim/tb_usb_endpoint_context_builder_core.sv =====
// Self-checking bench for usb_endpoint_context_builder_core: drives descriptors,
// predicts xHCI endpoint context fields and checks every context transfer.
// Depends on usbepc_pkg and the core RTL only.
module tb_usb_endpoint_context_builder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 4000;  // cycles without any transfer
  localparam int unsigned SegItems   = 235;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [3:0]                      cfg_wdata_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [usbepc_pkg::InDataW-1:0]  s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [usbepc_pkg::OutDataW-1:0] m_axis_tdata;
  logic [2:0]                      m_axis_tuser;

  // Predictor state: mirror of the port speed register and the running max index
  logic [3:0] port_speed_q;
  logic [4:0] highest_ctx;

  usbepc_pkg::ctx_t pending_contexts[$];
  int unsigned      descriptors_sent;
  int unsigned      contexts_checked = 0;
  int unsigned      mismatches = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      src_idle_pct;
  int unsigned      snk_stall_pct = 0;

  usb_endpoint_context_builder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Context predictor
  // ---------------------------------------------------------------------------
  function automatic logic [4:0] interval_exp(usbepc_pkg::xfer_type_e xt,
                                              logic [7:0] iv, logic [3:0] spd);
    int unsigned ival_i;
    int unsigned lim;
    int unsigned scaled;
    int unsigned lg;
    ival_i = iv;
    lim    = (ival_i < 1) ? 1 : (ival_i > 16) ? 16 : ival_i;
    scaled = (ival_i == 0) ? 1 : (ival_i * 8 > 255) ? 255 : ival_i * 8;
    lg     = $clog2(scaled + 1) - 1;  // floor(log2)
    if (xt == usbepc_pkg::XFER_CONTROL || xt == usbepc_pkg::XFER_BULK) begin
      return 5'd0;
    end else if (spd == usbepc_pkg::SPEED_FULL && xt == usbepc_pkg::XFER_ISOCH) begin
      return 5'(lim + 2);
    end else if (spd == usbepc_pkg::SPEED_FULL || spd == usbepc_pkg::SPEED_LOW) begin
      // full-speed interrupt follows the low-speed frame rule
      return 5'((lg < 3) ? 3 : (lg > 10) ? 10 : lg);
    end
    return 5'(lim - 1);
  endfunction

  function automatic usbepc_pkg::ctx_t build_context(usbepc_pkg::desc_t d);
    usbepc_pkg::ctx_t       c;
    usbepc_pkg::xfer_type_e xt;
    logic                   dir_in;
    logic                   periodic;
    logic [4:0]             idx;
    logic [15:0]            pkt;
    logic [3:0]             bst;
    logic [19:0]            payload;
    xt       = usbepc_pkg::xfer_type_e'(d.attr[1:0]);
    dir_in   = d.ep_addr[7];
    idx      = {d.ep_addr[3:0], dir_in};
    periodic = (xt == usbepc_pkg::XFER_ISOCH) || (xt == usbepc_pkg::XFER_INTR);
    if (idx > highest_ctx) highest_ctx = idx;

    case (xt)
      usbepc_pkg::XFER_CONTROL: c.kind = usbepc_pkg::KIND_CONTROL;
      usbepc_pkg::XFER_ISOCH:
        c.kind = dir_in ? usbepc_pkg::KIND_ISO_IN : usbepc_pkg::KIND_ISO_OUT;
      usbepc_pkg::XFER_BULK:
        c.kind = dir_in ? usbepc_pkg::KIND_BULK_IN : usbepc_pkg::KIND_BULK_OUT;
      default:
        c.kind = dir_in ? usbepc_pkg::KIND_INT_IN : usbepc_pkg::KIND_INT_OUT;
    endcase

    pkt = periodic ? {5'd0, d.mps_raw[10:0]} : d.mps_raw;
    // burst comes from the companion even on bulk/control endpoints
    if (d.comp)         bst = d.comp_burst;
    else if (periodic)  bst = {2'b00, d.mps_raw[12:11]};
    else                bst = 4'd0;
    payload = ({16'd0, bst} + 20'd1) * {4'd0, pkt};

    c.ctx_index   = idx;
    c.add_mask    = (32'd1 << idx) | 32'd1;
    c.ctx_entries = highest_ctx;
    c.ival_code   = interval_exp(xt, d.ival, port_speed_q);
    c.err_limit   = (xt == usbepc_pkg::XFER_ISOCH) ? 2'd0 : usbepc_pkg::ERR_LIMIT_MAX;
    c.mps         = pkt;
    c.burst       = bst;
    c.esit        = !periodic ? 16'd0 : d.comp ? d.comp_bpi : payload[15:0];
    if (xt == usbepc_pkg::XFER_CONTROL)    c.avg_trb = usbepc_pkg::CTRL_AVG_TRB;
    else if (xt == usbepc_pkg::XFER_ISOCH) c.avg_trb = {4'd0, pkt};
    else                                   c.avg_trb = payload;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic usbepc_pkg::desc_t make_desc(logic [7:0] addr, logic [7:0] attr,
                                                  logic [15:0] mps, logic [7:0] iv,
                                                  logic comp, logic [3:0] burst,
                                                  logic [15:0] bpi);
    usbepc_pkg::desc_t d;
    d.ep_addr    = addr;
    d.attr       = attr;
    d.mps_raw    = mps;
    d.ival       = iv;
    d.comp       = comp;
    d.comp_burst = burst;
    d.comp_bpi   = bpi;
    return d;
  endfunction

  // One descriptor transfer; tvalid stays high so back-to-back items stream.
  task automatic send_descriptor(input usbepc_pkg::desc_t d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, d.comp_bpi, d.comp_burst, d.ival, d.mps_raw,
                      d.attr, d.ep_addr};
    s_axis_tuser  <= d.comp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_contexts.push_back(build_context(d));
    descriptors_sent++;
  endtask

  // Hold the source off until every context has come back, plus pipeline slack.
  task automatic drain_contexts();
    s_axis_tvalid <= 1'b0;
    while (pending_contexts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_port_speed(input logic [3:0] spd);
    drain_contexts();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= spd;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    port_speed_q = spd;
  endtask

  function automatic usbepc_pkg::desc_t random_descriptor();
    usbepc_pkg::desc_t d;
    d.ep_addr = 8'($urandom);
    d.attr    = 8'($urandom);
    case ($urandom_range(3))
      0: d.mps_raw = 16'($urandom);
      1: d.mps_raw = {3'($urandom), 2'($urandom), 4'd0, 7'($urandom_range(64))};
      2: d.mps_raw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: d.mps_raw = {3'd0, 2'($urandom), 11'($urandom)};
    endcase
    case ($urandom_range(2))
      0: d.ival = 8'($urandom);
      1: d.ival = 8'($urandom_range(20));
      default: d.ival = $urandom_range(1) ? 8'hFF : 8'h00;
    endcase
    d.comp       = 1'($urandom);
    d.comp_burst = 4'($urandom);
    d.comp_bpi   = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Endpoint zero both ways; companion attached to a control endpoint.
  task automatic test_endpoint_zero();
    send_descriptor(make_desc(8'h00, 8'h00, 16'd64, 8'd0, 1'b0, 4'd0, 16'd0));
    send_descriptor(make_desc(8'h80, 8'hFC, 16'hFFFF, 8'hFF, 1'b1, 4'hF, 16'hFFFF));
  endtask

  // Every transfer type in both directions, size and burst extremes.
  task automatic test_transfer_types();
    send_descriptor(make_desc(8'h01, 8'h01, 16'hFFFF, 8'd1, 1'b0, 4'd0, 16'd0));
    send_descriptor(make_desc(8'h81, 8'h05, 16'h1200, 8'd4, 1'b1, 4'd2, 16'hFFFF));
    send_descriptor(make_desc(8'h02, 8'h02, 16'hFFFF, 8'd0, 1'b1, 4'hF, 16'd1234));
    send_descriptor(make_desc(8'h82, 8'hFE, 16'd512, 8'd9, 1'b0, 4'd7, 16'd77));
    send_descriptor(make_desc(8'h03, 8'h03, 16'h1FFF, 8'hFF, 1'b0, 4'd0, 16'd0));
    send_descriptor(make_desc(8'h83, 8'hFF, 16'h0000, 8'd0, 1'b1, 4'd0, 16'd0));
    // upper address bits 6:4 are not part of the endpoint number
    send_descriptor(make_desc(8'h7F, 8'h00, 16'd8, 8'd0, 1'b0, 4'd0, 16'd0));
    send_descriptor(make_desc(8'h8F, 8'h00, 16'd8, 8'd0, 1'b0, 4'd0, 16'd0));
  endtask

  // Interval encoding per port speed, clamps at both ends.
  task automatic test_interval_speeds();
    set_port_speed(usbepc_pkg::SPEED_FULL);
    send_descriptor(make_desc(8'h05, 8'h01, 16'd64, 8'd0, 1'b0, 4'd0, 16'd0));
    send_descriptor(make_desc(8'h85, 8'h01, 16'd64, 8'hFF, 1'b0, 4'd0, 16'd0));
    send_descriptor(make_desc(8'h06, 8'h03, 16'd8, 8'd0, 1'b0, 4'd0, 16'd0));
    send_descriptor(make_desc(8'h86, 8'h03, 16'd8, 8'd4, 1'b0, 4'd0, 16'd0));
    send_descriptor(make_desc(8'h07, 8'h03, 16'd8, 8'hFF, 1'b0, 4'd0, 16'd0));
    set_port_speed(usbepc_pkg::SPEED_LOW);
    send_descriptor(make_desc(8'h87, 8'h03, 16'd8, 8'd1, 1'b0, 4'd0, 16'd0));
    send_descriptor(make_desc(8'h08, 8'h01, 16'd8, 8'd16, 1'b0, 4'd0, 16'd0));
    send_descriptor(make_desc(8'h88, 8'h03, 16'd8, 8'd2, 1'b0, 4'd0, 16'd0));
    set_port_speed(usbepc_pkg::SPEED_HIGH);
    send_descriptor(make_desc(8'h09, 8'h01, 16'd1024, 8'd0, 1'b0, 4'd0, 16'd0));
    send_descriptor(make_desc(8'h89, 8'h03, 16'd1024, 8'd17, 1'b0, 4'd0, 16'd0));
    // undefined speed code falls back to the high-speed rule
    set_port_speed(4'hF);
    send_descriptor(make_desc(8'h0A, 8'h03, 16'd1024, 8'hFF, 1'b0, 4'd0, 16'd0));
  endtask

  // Random descriptors over a series of speed codes and pacing mixes.
  task automatic test_random_traffic();
    logic [3:0]  seg_speed[8] = '{usbepc_pkg::SPEED_HIGH, usbepc_pkg::SPEED_FULL,
                                  usbepc_pkg::SPEED_LOW, usbepc_pkg::SPEED_SUPER,
                                  4'd0, 4'hF, usbepc_pkg::SPEED_FULL,
                                  usbepc_pkg::SPEED_LOW};
    int unsigned seg_src[8]   = '{0, 59, 0, 22, 0, 59, 0, 22};
    int unsigned seg_snk[8]   = '{0, 0, 59, 22, 0, 0, 59, 22};
    for (int s = 0; s < 8; s++) begin
      set_port_speed(seg_speed[s]);
      src_idle_pct  = seg_src[s];
      snk_stall_pct = seg_snk[s];
      for (int n = 0; n < SegItems; n++) send_descriptor(random_descriptor());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sink pacing, context checker, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h",
               $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    usbepc_pkg::ctx_t got;
    usbepc_pkg::ctx_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ctx_index   = m_axis_tdata[4:0];
      got.add_mask    = m_axis_tdata[36:5];
      got.ctx_entries = m_axis_tdata[41:37];
      got.ival_code   = m_axis_tdata[46:42];
      got.err_limit   = m_axis_tdata[48:47];
      got.mps         = m_axis_tdata[64:49];
      got.burst       = m_axis_tdata[68:65];
      got.esit        = m_axis_tdata[84:69];
      got.avg_trb     = m_axis_tdata[104:85];
      got.kind        = m_axis_tuser;
      if (pending_contexts.size() == 0) begin
        mismatches++;
        $display("%0t ns: context transfer with none expected, expected none actual 0x%0h",
                 $time, m_axis_tdata);
      end else begin
        want = pending_contexts.pop_front();
        check_field("context_index", 32'(want.ctx_index), 32'(got.ctx_index));
        check_field("slot add mask", want.add_mask, got.add_mask);
        check_field("context count", 32'(want.ctx_entries), 32'(got.ctx_entries));
        check_field("endpoint_kind", 32'(want.kind), 32'(got.kind));
        check_field("interval_code", 32'(want.ival_code), 32'(got.ival_code));
        check_field("error_limit", 32'(want.err_limit), 32'(got.err_limit));
        check_field("packet_size", 32'(want.mps), 32'(got.mps));
        check_field("burst", 32'(want.burst), 32'(got.burst));
        check_field("esit_payload", 32'(want.esit), 32'(got.esit));
        check_field("avg TRB length", 32'(want.avg_trb), 32'(got.avg_trb));
        contexts_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t ns: no transfer for %0d cycles, %0d contexts outstanding",
                 $time, StallLimit, pending_contexts.size());
        $display("** usb_endpoint_context_builder_core: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= 4'd0;
    s_axis_tvalid    <= 1'b0;
    s_axis_tdata     <= '0;
    s_axis_tuser     <= 1'b0;
    port_speed_q     = 4'd0;
    highest_ctx      = 5'd0;
    descriptors_sent = 0;
    src_idle_pct     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_endpoint_zero();
    test_transfer_types();
    test_interval_speeds();
    test_random_traffic();

    drain_contexts();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d contexts from %0d descriptors: all transfer types,",
             contexts_checked, descriptors_sent);
    $display("speed codes 0-4 and 15, companion on/off, four source/sink pacing mixes.");
    if (mismatches == 0 && pending_contexts.size() == 0) begin
      $display("** usb_endpoint_context_builder_core: PASSED **");
    end else begin
      $display("** usb_endpoint_context_builder_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/usbepc_pkg.sv
sv/usb_endpoint_context_builder_core.sv
sv/usbepc_checker.sv
sim/tb_usb_endpoint_context_builder_core.sv
